>>> hdl/sha256_pkg.sv
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  localparam logic [0:0] KIND_BYTE = 1'b0;
  localparam logic [0:0] KIND_END  = 1'b1;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef logic [31:0] word_t;

  // Start and done strobes between the sequencer and the compression core.
  typedef struct packed {
    logic start;
    logic done;
  } core_ctl_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

>>> hdl/sha256_core.sv
// Compression core: schedule memory, working variables and hash words.
`timescale 1ns / 1ps
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  core_ctl_t   ctl_in,
  output logic        done,
  // Block word fetch toward the buffer (rounds 0..15).
  output logic [3:0]  blk_addr,
  input  word_t       blk_word,
  // Hash readout and reload.
  input  logic        reload,
  input  logic [2:0]  hash_sel,
  output word_t       hash_word
);

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_LOAD  = 5'b00010,
    C_FETCH = 5'b00100,
    C_ROUND = 5'b01000,
    C_ADD   = 5'b10000
  } cstate_t;

  cstate_t cst_r, cst_nxt;
  logic [5:0] t_r, t_nxt;
  logic [1:0] ph_r, ph_nxt;
  word_t hash_r [8];
  word_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  word_t x2_r, x7_r, x15_r;

  // Schedule memory: one write port, one read port, registered read.
  word_t sched_mem [16];
  logic [3:0] rd_addr;
  logic       wr_en;
  logic [3:0] wr_addr;
  word_t      wr_data;
  word_t      rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sched_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= sched_mem[rd_addr];
  end

  // Each round from 16 on reads four taps over four phases.
  always_comb begin
    case (ph_r)
      2'd0:    rd_addr = t_r[3:0] - 4'd2;
      2'd1:    rd_addr = t_r[3:0] - 4'd7;
      2'd2:    rd_addr = t_r[3:0] - 4'd15;
      default: rd_addr = t_r[3:0];
    endcase
  end

  // The buffer address follows the next round index, so the word is ready on time.
  assign blk_addr = t_nxt[3:0];
  word_t w_new, w_cur, t1, t2;
  // The oldest tap, word t-16, is the read data that returns as the round begins.
  assign w_new = sig1(x2_r) + x7_r + sig0(x15_r) + rd_data_r;
  assign w_cur = (t_r < 6'd16) ? blk_word : w_new;
  assign t1 = h_r + bsig1(e_r) + ((e_r & f_r) ^ (~e_r & g_r)) + ROUND_K[t_r] + w_cur;
  assign t2 = bsig0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  assign wr_en = (cst_r == C_ROUND);
  assign wr_addr = t_r[3:0];
  assign wr_data = w_cur;
  assign done = (cst_r == C_ADD);
  assign hash_word = hash_r[hash_sel];

  // Sequencer for the 64 rounds.
  always_comb begin
    cst_nxt = cst_r;
    t_nxt = t_r;
    ph_nxt = ph_r;
    case (cst_r)
      C_IDLE: begin
        if (ctl_in.start) begin
          cst_nxt = C_LOAD;
        end
      end
      C_LOAD: begin
        t_nxt = 6'd0;
        cst_nxt = C_ROUND;
      end
      C_FETCH: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          cst_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        t_nxt = t_r + 6'd1;
        ph_nxt = 2'd0;
        if (t_r == 6'(ROUNDS - 1)) begin
          cst_nxt = C_ADD;
        end else if (t_r >= 6'd15) begin
          cst_nxt = C_FETCH;
        end
      end
      C_ADD:   cst_nxt = C_IDLE;
      default: cst_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
      t_r <= 6'd0;
      ph_r <= 2'd0;
    end else begin
      cst_r <= cst_nxt;
      t_r <= t_nxt;
      ph_r <= ph_nxt;
    end
  end

  // Schedule taps are captured from the registered read data in the phase after their read address.
  always_ff @(posedge clk) begin
    if (cst_r == C_FETCH) begin
      case (ph_r)
        2'd1:    x2_r <= rd_data_r;
        2'd2:    x7_r <= rd_data_r;
        2'd3:    x15_r <= rd_data_r;
        default: ;
      endcase
    end
  end

  // Working variables and hash words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= START_HASH[i];
    end else if (reload) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= START_HASH[i];
    end else if (cst_r == C_ADD) begin
      hash_r[0] <= hash_r[0] + a_r; hash_r[1] <= hash_r[1] + b_r;
      hash_r[2] <= hash_r[2] + c_r; hash_r[3] <= hash_r[3] + d_r;
      hash_r[4] <= hash_r[4] + e_r; hash_r[5] <= hash_r[5] + f_r;
      hash_r[6] <= hash_r[6] + g_r; hash_r[7] <= hash_r[7] + h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cst_r == C_LOAD) begin
      a_r <= hash_r[0]; b_r <= hash_r[1]; c_r <= hash_r[2]; d_r <= hash_r[3];
      e_r <= hash_r[4]; f_r <= hash_r[5]; g_r <= hash_r[6]; h_r <= hash_r[7];
    end else if (cst_r == C_ROUND) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

endmodule

>>> hdl/sha256_buffer.sv
// Block buffer memory: byte writes, word reads for the compression core.
`timescale 1ns / 1ps
module sha256_buffer
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [3:0] rd_addr,
  output word_t      rd_word
);

  // Four byte lanes, so a big-endian word reads in one access.
  logic [7:0] lane0 [16];
  logic [7:0] lane1 [16];
  logic [7:0] lane2 [16];
  logic [7:0] lane3 [16];
  word_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr[1:0])
        2'd0:    lane0[wr_addr[5:2]] <= wr_data;
        2'd1:    lane1[wr_addr[5:2]] <= wr_data;
        2'd2:    lane2[wr_addr[5:2]] <= wr_data;
        default: lane3[wr_addr[5:2]] <= wr_data;
      endcase
    end
    rd_r <= {lane0[rd_addr], lane1[rd_addr], lane2[rd_addr], lane3[rd_addr]};
  end

  assign rd_word = rd_r;

endmodule

>>> hdl/sha256_hash_engine_top.sv
// Top level of the SHA-256 engine: input sequencer, padding and digest output.
// A message byte goes straight into the block buffer; once a byte fills the block,
// the full block compresses (16 rounds on block buffer words, then 48 rounds
// with four schedule memory reads each, plus start, load and final add).
// An end item pads one byte a cycle, compresses one or two blocks, then gives
// eight digest transactions, one a cycle while out_stall is low.
// Synchronous active-low reset loads the initial hash and clears the count.
`timescale 1ns / 1ps
module sha256_hash_engine_top
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_message_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COMP  = 7'b0000010,
    S_PAD   = 7'b0000100,
    S_PCOMP = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [63:0] cnt_r;
  logic [5:0] pos_r;
  logic final_r;
  logic [2:0] oidx_r;
  logic start_r;
  core_ctl_t ctl;
  logic done;
  logic [3:0] blk_addr;
  word_t blk_word, hash_word;
  logic bwr_en;
  logic [5:0] bwr_addr;
  logic [7:0] bwr_data;

  assign ctl.start = start_r;
  assign ctl.done = done;

  sha256_buffer u_buf (
    .clk(clk), .wr_en(bwr_en), .wr_addr(bwr_addr), .wr_data(bwr_data),
    .rd_addr(blk_addr), .rd_word(blk_word)
  );

  // The core fetches block word t in the cycle before round t uses it.
  sha256_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl), .done(done),
    .blk_addr(blk_addr), .blk_word(blk_word),
    .reload(st_r == S_FIN), .hash_sel(oidx_r), .hash_word(hash_word)
  );

  logic acc;
  assign in_stall = (st_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  // Buffer write: input bytes in idle, padding bytes in the pad state.
  always_comb begin
    bwr_en = 1'b0;
    bwr_addr = pos_r;
    bwr_data = in_message_byte;
    if (acc) begin
      bwr_en = 1'b1;
      bwr_data = (in_kind == KIND_END) ? PAD_BYTE : in_message_byte;
    end else if (st_r == S_PAD) begin
      bwr_en = 1'b1;
      if (final_r && pos_r >= 6'(LEN_POS)) begin
        bwr_data = cnt_r[8'(63 - 8 * (pos_r - 6'(LEN_POS))) -: 8];
      end else begin
        bwr_data = 8'h00;
      end
    end
  end

  // Main sequencer. A pad byte in the last slot fills the block at once.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (pos_r == 6'd63) st_nxt = (in_kind == KIND_END) ? S_PCOMP : S_COMP;
          else if (in_kind == KIND_END) st_nxt = S_PAD;
        end
      end
      S_COMP:  if (done) st_nxt = S_IDLE;
      S_PAD:   if (pos_r == 6'd63) st_nxt = S_PCOMP;
      S_PCOMP: if (done) st_nxt = final_r ? S_OUT : S_PAD;
      S_WAIT:  st_nxt = S_OUT;
      S_OUT:   if (!out_stall && oidx_r == 3'd7) st_nxt = S_FIN;
      S_FIN:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= 64'd0;
      pos_r <= 6'd0;
      final_r <= 1'b0;
      oidx_r <= 3'd0;
      start_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      start_r <= 1'b0;
      if (acc) begin
        pos_r <= pos_r + 6'd1;
        if (pos_r == 6'd63) start_r <= 1'b1;
        if (in_kind == KIND_BYTE) begin
          cnt_r <= cnt_r + 64'd8;
        end else begin
          final_r <= (pos_r < 6'(LEN_POS));
        end
      end else if (st_r == S_PAD) begin
        pos_r <= pos_r + 6'd1;
        if (pos_r == 6'd63) start_r <= 1'b1;
      end else if (st_r == S_PCOMP && done) begin
        final_r <= 1'b1;
      end else if (st_r == S_OUT && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
      end else if (st_r == S_FIN) begin
        cnt_r <= 64'd0;
        pos_r <= 6'd0;
        oidx_r <= 3'd0;
      end
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_digest_word = hash_word;
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

endmodule

>>> hdl/sha256_checker.sv
// Port checker for the SHA-256 engine, bound to the top level.
`timescale 1ns / 1ps
module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // The last flag marks exactly the eighth word.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");

  // Input is held off while digest words are out.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest");

  // Words advance by one after each transaction.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("word index skipped");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled word changed");

endmodule

bind sha256_hash_engine_top sha256_checker u_chk (.*);
